FILE: design/mjdcd_pkg.sv
// Shared types and constants for the MJD to civil date converter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mjdcd_pkg;

  // Pipeline depth: stages 0..3 split days into 400-year cycles,
  // stages 4..10 finish the calendar fields.
  localparam int unsigned NumStg   = 11;
  localparam int unsigned FirstCal = 4;

  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;

  // Day offset 678881 plus 14700 whole 400-year cycles, so the dividend
  // never goes negative.
  localparam logic signed [33:0] DayBias = 34'sd2148304781;
  localparam logic signed [15:0] QBias   = 16'sd14700;

  localparam logic [17:0] Days400   = 18'd146097;
  localparam logic [18:0] Days400x1 = 19'd146097;
  localparam logic [18:0] Days400x2 = 19'd292194;
  localparam logic [17:0] Days100x1 = 18'd36524;
  localparam logic [17:0] Days100x2 = 18'd73048;
  localparam logic [17:0] Days100x3 = 18'd109572;
  localparam logic [10:0] Days4     = 11'd1461;
  localparam logic [10:0] Days1x1   = 11'd365;
  localparam logic [10:0] Days1x2   = 11'd730;
  localparam logic [10:0] Days1x3   = 11'd1095;
  localparam logic [10:0] MarToDec  = 11'd306;

  // Reciprocals for division by constants (multiply, then shift)
  localparam logic [15:0] Recip400  = 16'd58796;   // >> 33 overall
  localparam logic [15:0] Recip4    = 16'd45934;   // >> 26
  localparam logic [17:0] Recip7    = 18'd149797;  // >> 20
  localparam logic [15:0] RecipHour = 16'd37283;   // >> 27
  localparam logic [12:0] RecipMin  = 13'd4370;    // >> 18
  localparam logic [11:0] RecipMon  = 12'd3427;    // >> 20
  localparam logic [15:0] RecipTen  = 16'd205;     // >> 11

  typedef struct packed {
    logic [16:0] sec;
    logic        leap;
  } sod_t;

  typedef struct packed {
    logic [15:0] q;      // signed count of 400-year cycles
    logic [17:0] r;      // day within the cycle
  } cyc_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } tod_t;

  typedef struct packed {
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [23:0] year;
    logic [2:0]  wday;
    logic [8:0]  yday;
  } cal_t;

endpackage

`default_nettype wire

FILE: design/mjd_to_civil_date_top.sv
// Top level of the MJD to civil date converter: pipeline control and the
// three datapath parts. Depends on mjdcd_pkg, mjdcd_div, mjdcd_tod, mjdcd_cal.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries a signed modified Julian
//   day number and a signed second-of-day count; any bit pattern is legal.
//   Output channel (out_valid_o / out_ready_i) carries the broken-down time:
//   second (60 for a leap second), minute, hour, day of month, month 0..11,
//   year minus 1900, weekday (0 is Sunday) and day of year.
//   A result passes register stages 0..10 from input transfer to output
//   valid. One transfer per cycle is accepted and delivered while
//   out_ready_i stays high; the rate is set by the 11-stage pipeline, each
//   stage holding one shallow step of constant-coefficient arithmetic.
//   Each stage advances when it is empty or the stage after it advances,
//   so empty slots close up while the receiver stalls and in_ready_o drops
//   only once all 11 stages hold an item. A stalled result stays on the
//   output registers unchanged until taken.
//   Reset clears every stage valid bit; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module mjd_to_civil_date_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] day_number_i,
  input  wire logic signed [18:0] second_of_day_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [5:0]              second_o,
  output logic [5:0]              minute_o,
  output logic [4:0]              hour_o,
  output logic [4:0]              day_of_month_o,
  output logic [3:0]              month_o,
  output logic signed [23:0]      year_since_1900_o,
  output logic [2:0]              weekday_o,
  output logic [8:0]              day_of_year_o
);
  import mjdcd_pkg::*;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] adv;
  sod_t              sod;
  cyc_t              cyc;
  tod_t              tod;
  cal_t              cal;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  mjdcd_div u_div (
    .clk_i          (clk_i),
    .adv_i          (adv[FirstCal-1:0]),
    .day_number_i   (day_number_i),
    .second_of_day_i(second_of_day_i),
    .sod_o          (sod),
    .cyc_o          (cyc)
  );

  mjdcd_tod u_tod (
    .clk_i(clk_i),
    .adv_i(adv[NumStg-1:1]),
    .sod_i(sod),
    .tod_o(tod)
  );

  mjdcd_cal u_cal (
    .clk_i(clk_i),
    .adv_i(adv[NumStg-1:FirstCal]),
    .cyc_i(cyc),
    .cal_o(cal)
  );

  assign in_ready_o        = adv[0];
  assign out_valid_o       = vld_q[NumStg-1];
  assign second_o          = tod.second;
  assign minute_o          = tod.minute;
  assign hour_o            = tod.hour;
  assign day_of_month_o    = cal.mday;
  assign month_o           = cal.month;
  assign year_since_1900_o = $signed(cal.year);
  assign weekday_o         = cal.wday;
  assign day_of_year_o     = cal.yday;

  // input stalls only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with an empty pipeline stage");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o <= 4'd11) && (hour_o <= 5'd23) && (minute_o <= 6'd59)
                    && (second_o <= 6'd60) && (weekday_o <= 3'd6))
    else $error("result field out of range");

  a_leap_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (second_o == 6'd60)) |-> (minute_o == 6'd59) && (hour_o == 5'd23))
    else $error("leap second not at 23:59");

  a_new_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (day_of_year_o == 9'd0)) |-> (month_o == 4'd0) && (day_of_month_o == 5'd1))
    else $error("day zero of the year is not January 1");

  a_year_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (day_of_year_o >= 9'd365)) |-> (month_o == 4'd11) && (day_of_month_o == 5'd31))
    else $error("day 365 of the year is not December 31");

endmodule

`default_nettype wire

FILE: design/mjdcd_div.sv
// Stages 0..3: second normalization and floor division of the day count
// into 400-year cycles. Depends on mjdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjdcd_div (
  input  wire logic               clk_i,
  input  wire logic [3:0]         adv_i,
  input  wire logic signed [31:0] day_number_i,
  input  wire logic signed [18:0] second_of_day_i,
  output mjdcd_pkg::sod_t         sod_o,
  output mjdcd_pkg::cyc_t         cyc_o
);
  import mjdcd_pkg::*;

  logic signed [19:0] sx;
  logic signed [19:0] s_adj;
  logic signed [3:0]  d_adj;
  logic [16:0]        s_norm;
  logic signed [33:0] n_sum;
  sod_t               sod_d, sod_q;
  logic [32:0]        n_d, n_q, n1_q, n2_q;
  logic [37:0]        prod1;
  logic [14:0]        qe_d, qe_q, qe2_q;
  logic [32:0]        prod2_d, prod2_q;
  logic [32:0]        r0;
  logic [18:0]        r0s;
  logic [18:0]        r_fix;
  logic [1:0]         q_inc;
  cyc_t               cyc_d, cyc_q;

  // Stage 0: fold seconds into 0..86400, move the day accordingly
  always_comb begin
    sx = {second_of_day_i[18], second_of_day_i};
    if (sx < -20'sd259200) begin
      d_adj = -4'sd4;
      s_adj = sx + 20'sd345600;
    end else if (sx < -20'sd172800) begin
      d_adj = -4'sd3;
      s_adj = sx + 20'sd259200;
    end else if (sx < -20'sd86400) begin
      d_adj = -4'sd2;
      s_adj = sx + 20'sd172800;
    end else if (sx < 20'sd0) begin
      d_adj = -4'sd1;
      s_adj = sx + 20'sd86400;
    end else if (sx > 20'sd259200) begin
      d_adj = 4'sd3;
      s_adj = sx - 20'sd259200;
    end else if (sx > 20'sd172800) begin
      d_adj = 4'sd2;
      s_adj = sx - 20'sd172800;
    end else if (sx > 20'sd86400) begin
      d_adj = 4'sd1;
      s_adj = sx - 20'sd86400;
    end else begin
      d_adj = 4'sd0;
      s_adj = sx;
    end
    s_norm     = s_adj[16:0];
    sod_d.leap = (s_norm == SecPerDay);
    sod_d.sec  = sod_d.leap ? (SecPerDay - 17'd1) : s_norm;
    n_sum      = $signed({{2{day_number_i[31]}}, day_number_i}) + DayBias
               + $signed({{30{d_adj[3]}}, d_adj});
    n_d        = n_sum[32:0];
  end

  // Stage 1: quotient estimate from the top bits, may be up to two low
  assign prod1 = {16'd0, n_q[32:11]} * {22'd0, Recip400};
  assign qe_d  = prod1[36:22];

  // Stage 2: back-multiply the estimate
  assign prod2_d = {18'd0, qe_q} * {15'd0, Days400};

  // Stage 3: remainder and final correction
  always_comb begin
    r0  = n2_q - prod2_q;
    r0s = r0[18:0];
    if (r0s >= Days400x2) begin
      q_inc = 2'd2;
      r_fix = r0s - Days400x2;
    end else if (r0s >= Days400x1) begin
      q_inc = 2'd1;
      r_fix = r0s - Days400x1;
    end else begin
      q_inc = 2'd0;
      r_fix = r0s;
    end
    cyc_d.r = r_fix[17:0];
    cyc_d.q = $signed({1'b0, qe2_q}) + $signed({14'd0, q_inc}) - QBias;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      sod_q <= sod_d;
      n_q   <= n_d;
    end
    if (adv_i[1]) begin
      qe_q <= qe_d;
      n1_q <= n_q;
    end
    if (adv_i[2]) begin
      prod2_q <= prod2_d;
      qe2_q   <= qe_q;
      n2_q    <= n1_q;
    end
    if (adv_i[3]) begin
      cyc_q <= cyc_d;
    end
  end

  assign sod_o = sod_q;
  assign cyc_o = cyc_q;

endmodule

`default_nettype wire

FILE: design/mjdcd_tod.sv
// Stages 1..10: hour, minute and second from the normalized second count,
// then held in step with the date path. Depends on mjdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjdcd_tod (
  input  wire logic                          clk_i,
  input  wire logic [mjdcd_pkg::NumStg-1:1]  adv_i,
  input  wire mjdcd_pkg::sod_t               sod_i,
  output mjdcd_pkg::tod_t                    tod_o
);
  import mjdcd_pkg::*;

  logic [32:0] hprod;
  logic [4:0]  hour1_q, hour2_q, hour3_q;
  logic [16:0] sec1_q;
  logic        leap1_q, leap2_q, leap3_q;
  logic [16:0] hsec;
  logic [16:0] rs_full;
  logic [11:0] rs2_q, rs3_q;
  logic [23:0] mprod;
  logic [5:0]  minute3_q;
  logic [11:0] msec;
  logic [11:0] s_full;
  tod_t        tod_d;
  tod_t        pipe_q [NumStg-1:FirstCal];

  assign hprod   = {16'd0, sod_i.sec} * {17'd0, RecipHour};
  assign hsec    = {12'd0, hour1_q} * SecPerHour;
  assign rs_full = sec1_q - hsec;
  assign mprod   = {12'd0, rs2_q} * {11'd0, RecipMin};
  assign msec    = {6'd0, minute3_q} * 12'd60;
  assign s_full  = rs3_q - msec;

  always_comb begin
    tod_d.hour   = hour3_q;
    tod_d.minute = minute3_q;
    tod_d.second = s_full[5:0] + {5'd0, leap3_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      hour1_q <= hprod[31:27];
      sec1_q  <= sod_i.sec;
      leap1_q <= sod_i.leap;
    end
    if (adv_i[2]) begin
      rs2_q   <= rs_full[11:0];
      hour2_q <= hour1_q;
      leap2_q <= leap1_q;
    end
    if (adv_i[3]) begin
      minute3_q <= mprod[23:18];
      rs3_q     <= rs2_q;
      hour3_q   <= hour2_q;
      leap3_q   <= leap2_q;
    end
    if (adv_i[FirstCal]) begin
      pipe_q[FirstCal] <= tod_d;
    end
    for (int k = FirstCal + 1; k < NumStg; k++) begin
      if (adv_i[k]) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign tod_o = pipe_q[NumStg-1];

endmodule

`default_nettype wire

FILE: design/mjdcd_cal.sv
// Stages 4..10: century, 4-year and year split, March-based month and day,
// weekday, day of year and year field. Depends on mjdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mjdcd_cal (
  input  wire logic                                clk_i,
  input  wire logic [mjdcd_pkg::NumStg-1:mjdcd_pkg::FirstCal] adv_i,
  input  wire mjdcd_pkg::cyc_t                     cyc_i,
  output mjdcd_pkg::cal_t                          cal_o
);
  import mjdcd_pkg::*;

  // stage 4
  logic [1:0]  cent_d;
  logic [17:0] cent_off;
  logic [17:0] r1_full;
  logic [15:0] q4_q;
  logic [1:0]  cent4_q;
  logic [15:0] r14_q;
  logic [17:0] x74_q;
  // stage 5
  logic [31:0] bprod;
  logic [35:0] wprod;
  logic [15:0] q5_q;
  logic [1:0]  cent5_q;
  logic [15:0] r15_q;
  logic [4:0]  block5_q;
  logic [17:0] x75_q;
  logic [14:0] q75_q;
  // stage 6
  logic [15:0]        bdays;
  logic [15:0]        r4_full;
  logic [17:0]        wmul;
  logic [17:0]        wdiff;
  logic [8:0]         cdays;
  logic signed [24:0] y400, y100, y4, ybase6_d;
  logic [10:0]        r46_q;
  logic [2:0]         wday6_q;
  logic signed [24:0] yb6_q;
  logic               cb6_q;
  // stage 7
  logic [1:0]         yy;
  logic [10:0]        ydays;
  logic [10:0]        rr_full;
  logic [8:0]         rr7_q;
  logic               lp7_q;
  logic signed [24:0] yb7_q;
  logic [2:0]         wday7_q;
  // stage 8
  logic [11:0]        xm;
  logic [23:0]        mprod;
  logic [3:0]         month8_q;
  logic [11:0]        xm8_q;
  logic [8:0]         rr8_q;
  logic               lp8_q;
  logic signed [24:0] yb8_q;
  logic [2:0]         wday8_q;
  // stage 9
  logic [11:0]        mdays;
  logic [11:0]        rem_full;
  logic               carry;
  logic [3:0]         month_d;
  logic [9:0]         yd_base;
  logic [9:0]         yd_full;
  logic signed [24:0] y1, yr_full;
  logic [8:0]         rem9_q;
  logic [3:0]         month9_q;
  logic [8:0]         yday9_q;
  logic [23:0]        year9_q;
  logic [2:0]         wday9_q;
  // stage 10
  logic [15:0]        dprod;
  cal_t               cal_d, cal_q;

  // Stage 4: century within the 400-year cycle; the last day of the
  // cycle belongs to the fourth century
  always_comb begin
    if (cyc_i.r == Days400 - 18'd1) begin
      cent_d   = 2'd3;
      cent_off = Days100x3;
    end else if (cyc_i.r >= Days100x3) begin
      cent_d   = 2'd3;
      cent_off = Days100x3;
    end else if (cyc_i.r >= Days100x2) begin
      cent_d   = 2'd2;
      cent_off = Days100x2;
    end else if (cyc_i.r >= Days100x1) begin
      cent_d   = 2'd1;
      cent_off = Days100x1;
    end else begin
      cent_d   = 2'd0;
      cent_off = 18'd0;
    end
    r1_full = cyc_i.r - cent_off;
  end

  // Stage 5: 4-year block and weekday quotient
  assign bprod = {16'd0, r14_q} * {16'd0, Recip4};
  assign wprod = {18'd0, x74_q} * {18'd0, Recip7};

  // Stage 6: day within block, weekday, year base
  always_comb begin
    bdays    = {11'd0, block5_q} * {5'd0, Days4};
    r4_full  = r15_q - bdays;
    wmul     = {3'd0, q75_q} * 18'd7;
    wdiff    = x75_q - wmul;
    cdays    = {7'd0, cent5_q} * 9'd100;
    y400     = $signed({{9{q5_q[15]}}, q5_q}) * 25'sd400;
    y100     = $signed({16'd0, cdays});
    y4       = $signed({18'd0, block5_q, 2'b00});
    ybase6_d = y400 + y100 + y4;
  end

  // Stage 7: year within block; the last day of a block is year three
  always_comb begin
    if (r46_q == Days4 - 11'd1) begin
      yy    = 2'd3;
      ydays = Days1x3;
    end else if (r46_q >= Days1x3) begin
      yy    = 2'd3;
      ydays = Days1x3;
    end else if (r46_q >= Days1x2) begin
      yy    = 2'd2;
      ydays = Days1x2;
    end else if (r46_q >= Days1x1) begin
      yy    = 2'd1;
      ydays = Days1x1;
    end else begin
      yy    = 2'd0;
      ydays = 11'd0;
    end
    rr_full = r46_q - ydays;
  end

  // Stage 8: March-based month
  assign xm    = {3'd0, rr7_q} * 12'd10 + 12'd5;
  assign mprod = {12'd0, xm} * {12'd0, RecipMon};

  // Stage 9: shift to January-based year, day of year, year field
  always_comb begin
    mdays    = {8'd0, month8_q} * {1'b0, MarToDec};
    rem_full = xm8_q - mdays;
    carry    = (month8_q >= 4'd10);
    month_d  = carry ? (month8_q - 4'd10) : (month8_q + 4'd2);
    yd_base  = {1'b0, rr8_q} + {9'd0, lp8_q};
    yd_full  = carry ? (yd_base - {1'b0, MarToDec[8:0]}) : (yd_base + 10'd59);
    y1       = yb8_q + $signed({24'd0, carry});
    // no year zero: astronomical years below one move down by one
    yr_full  = y1 - 25'sd1900 - $signed({24'd0, (y1 < 25'sd1)});
  end

  // Stage 10: day of month
  assign dprod = {7'd0, rem9_q} * RecipTen;

  always_comb begin
    cal_d.mday  = dprod[15:11] + 5'd1;
    cal_d.month = month9_q;
    cal_d.year  = year9_q;
    cal_d.wday  = wday9_q;
    cal_d.yday  = yday9_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      q4_q    <= cyc_i.q;
      cent4_q <= cent_d;
      r14_q   <= r1_full[15:0];
      x74_q   <= cyc_i.r + 18'd3;
    end
    if (adv_i[5]) begin
      q5_q     <= q4_q;
      cent5_q  <= cent4_q;
      r15_q    <= r14_q;
      block5_q <= bprod[30:26];
      x75_q    <= x74_q;
      q75_q    <= wprod[34:20];
    end
    if (adv_i[6]) begin
      r46_q   <= r4_full[10:0];
      wday6_q <= wdiff[2:0];
      yb6_q   <= ybase6_d;
      cb6_q   <= (cent5_q != 2'd0) && (block5_q == 5'd0);
    end
    if (adv_i[7]) begin
      rr7_q   <= rr_full[8:0];
      lp7_q   <= (r46_q < MarToDec) && !cb6_q;
      yb7_q   <= yb6_q + $signed({23'd0, yy});
      wday7_q <= wday6_q;
    end
    if (adv_i[8]) begin
      month8_q <= mprod[23:20];
      xm8_q    <= xm;
      rr8_q    <= rr7_q;
      lp8_q    <= lp7_q;
      yb8_q    <= yb7_q;
      wday8_q  <= wday7_q;
    end
    if (adv_i[9]) begin
      rem9_q   <= rem_full[8:0];
      month9_q <= month_d;
      yday9_q  <= yd_full[8:0];
      year9_q  <= yr_full[23:0];
      wday9_q  <= wday8_q;
    end
    if (adv_i[10]) begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

`default_nettype wire
